FILE: rtl/core/ipav_pkg.sv
package ipav_pkg;

  // Value layout
  localparam int unsigned HeaderBytes = 4;
  localparam logic [31:0] HEADER_LAST = 32'(HeaderBytes - 1);
  localparam logic [31:0] HEADER_LEN  = 32'(HeaderBytes);
  localparam logic [31:0] BYTES_MAX   = 32'hFFFF_FFFF;
  localparam logic [16:0] TALLY_MAX   = 17'h1_0000;
  localparam logic [7:0]  NUL_BYTE    = 8'h00;

  // Stream widths
  localparam int unsigned DataBytes   = 1;
  localparam int unsigned ResultBits  = 52;
  localparam int unsigned OutBytes    = (ResultBits + 7) / 8;
  localparam int unsigned OutPadBits  = OutBytes * 8 - ResultBits;

  // Parse position within the value
  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_NAME_LEN  = 3'd1,
    PH_NAME_BODY = 3'd2,
    PH_VER_LEN   = 3'd3,
    PH_VER_BODY  = 3'd4
  } phase_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_NAME_CUT = 3'd2,
    ST_NAME_NUL = 3'd3,
    ST_VER_CUT  = 3'd4,
    ST_VER_NUL  = 3'd5,
    ST_MISMATCH = 3'd6
  } status_e;

  // One result word, status in the lowest bits
  typedef struct packed {
    logic [16:0] packages_seen;
    logic [31:0] error_offset;
    status_e     status;
  } result_t;

endpackage

FILE: rtl/core/installed_packages_attr_validator_unit.sv
// A last byte passes from the byte register to the result buffer, which presents its result word.
// One byte per cycle unless a last byte meets a full buffer; parse state updates in one pass.
// A two-entry result buffer lets input flow continue while a result waits for tready.
// Reset (rst_ni low, asynchronous): parse state returns to the header phase, all counters,
// the latched error and both buffers are emptied. No clearing pass is needed.
module installed_packages_attr_validator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // end_of_value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o    // [2:0] status, [34:3] error_offset,
                                        // [51:35] packages_seen, [55:52] zero
);

  // Input register
  logic                in_vld_q;
  logic [7:0]          in_byte_q;
  logic                in_last_q;

  // Parse state
  ipav_pkg::phase_e    phase_q, phase_d;
  logic [31:0]         bytes_q, bytes_d;
  logic [15:0]         count_q, count_d;
  logic [7:0]          rem_q, rem_d;
  logic [31:0]         fstart_q, fstart_d;
  logic                nul_q, nul_d;
  logic [31:0]         nulpos_q, nulpos_d;
  logic [16:0]         tally_q, tally_d;
  logic                err_q, err_d;
  ipav_pkg::status_e   code_q, code_d;
  logic [31:0]         eoff_q, eoff_d;

  // Result buffer
  logic [1:0]          cnt_q, cnt_d;
  ipav_pkg::result_t   head_q, tail_q;
  ipav_pkg::result_t   res;

  logic                adv;
  logic                push;
  logic                pop;
  logic                s_fire;
  logic [31:0]         pos;
  logic [16:0]         tally_inc;

  // Advance the byte register unless its result has no room
  assign adv    = in_vld_q && (!in_last_q || (cnt_q != 2'd2));
  assign push   = adv && in_last_q;
  assign pop    = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = !in_vld_q || adv;
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;

  assign pos       = bytes_q;
  assign tally_inc = (tally_q < ipav_pkg::TALLY_MAX) ? tally_q + 17'd1 : tally_q;

  // Capture the incoming word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // Parse one byte and build the result
  always_comb begin
    phase_d  = phase_q;
    bytes_d  = bytes_q;
    count_d  = count_q;
    rem_d    = rem_q;
    fstart_d = fstart_q;
    nul_d    = nul_q;
    nulpos_d = nulpos_q;
    tally_d  = tally_q;
    err_d    = err_q;
    code_d   = code_q;
    eoff_d   = eoff_q;
    res      = '0;

    if (!err_q) begin
      case (phase_q)
        ipav_pkg::PH_HEADER: begin
          count_d = {count_q[7:0], in_byte_q};
          if (pos >= ipav_pkg::HEADER_LAST) begin
            phase_d = ipav_pkg::PH_NAME_LEN;
          end
        end
        ipav_pkg::PH_NAME_LEN, ipav_pkg::PH_VER_LEN: begin
          fstart_d = pos;
          rem_d    = in_byte_q;
          nul_d    = 1'b0;
          nulpos_d = '0;
          if (phase_q == ipav_pkg::PH_NAME_LEN) begin
            phase_d = (in_byte_q == 8'd0) ? ipav_pkg::PH_VER_LEN : ipav_pkg::PH_NAME_BODY;
          end else if (in_byte_q == 8'd0) begin
            // empty version closes the entry
            tally_d = tally_inc;
            phase_d = ipav_pkg::PH_NAME_LEN;
          end else begin
            phase_d = ipav_pkg::PH_VER_BODY;
          end
        end
        ipav_pkg::PH_NAME_BODY, ipav_pkg::PH_VER_BODY: begin
          if (in_byte_q == ipav_pkg::NUL_BYTE && !nul_q) begin
            nul_d    = 1'b1;
            nulpos_d = pos;
          end
          rem_d = rem_q - 8'd1;
          // close the field on its last byte
          if (rem_d == 8'd0) begin
            if (nul_d) begin
              err_d  = 1'b1;
              eoff_d = nulpos_d;
              code_d = (phase_q == ipav_pkg::PH_NAME_BODY) ? ipav_pkg::ST_NAME_NUL
                                                           : ipav_pkg::ST_VER_NUL;
            end else if (phase_q == ipav_pkg::PH_NAME_BODY) begin
              phase_d = ipav_pkg::PH_VER_LEN;
            end else begin
              tally_d = tally_inc;
              phase_d = ipav_pkg::PH_NAME_LEN;
            end
          end
        end
        default: begin
          phase_d = ipav_pkg::PH_HEADER;
        end
      endcase
    end

    if (bytes_q != ipav_pkg::BYTES_MAX) begin
      bytes_d = bytes_q + 32'd1;
    end

    // Select the status for the final byte
    res.packages_seen = tally_d;
    if (bytes_d < ipav_pkg::HEADER_LEN || phase_d == ipav_pkg::PH_HEADER) begin
      res.status        = ipav_pkg::ST_SHORT;
      res.error_offset  = '0;
      res.packages_seen = '0;
    end else if (err_d) begin
      res.status       = code_d;
      res.error_offset = eoff_d;
    end else if (phase_d == ipav_pkg::PH_NAME_LEN) begin
      res.status       = (tally_d == {1'b0, count_d}) ? ipav_pkg::ST_OK
                                                      : ipav_pkg::ST_MISMATCH;
      res.error_offset = bytes_d;
    end else if (phase_d == ipav_pkg::PH_NAME_BODY) begin
      res.status       = ipav_pkg::ST_NAME_CUT;
      res.error_offset = fstart_d;
    end else if (phase_d == ipav_pkg::PH_VER_LEN) begin
      res.status       = ipav_pkg::ST_VER_CUT;
      res.error_offset = bytes_d;
    end else begin
      res.status       = ipav_pkg::ST_VER_CUT;
      res.error_offset = fstart_d;
    end

    // Drop all state after the final byte
    if (in_last_q) begin
      phase_d  = ipav_pkg::PH_HEADER;
      bytes_d  = '0;
      count_d  = '0;
      rem_d    = '0;
      fstart_d = '0;
      nul_d    = 1'b0;
      nulpos_d = '0;
      tally_d  = '0;
      err_d    = 1'b0;
      code_d   = ipav_pkg::ST_OK;
      eoff_d   = '0;
    end
  end

  // Hold the parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ipav_pkg::PH_HEADER;
      bytes_q  <= '0;
      count_q  <= '0;
      rem_q    <= '0;
      fstart_q <= '0;
      nul_q    <= 1'b0;
      nulpos_q <= '0;
      tally_q  <= '0;
      err_q    <= 1'b0;
      code_q   <= ipav_pkg::ST_OK;
      eoff_q   <= '0;
    end else if (adv) begin
      phase_q  <= phase_d;
      bytes_q  <= bytes_d;
      count_q  <= count_d;
      rem_q    <= rem_d;
      fstart_q <= fstart_d;
      nul_q    <= nul_d;
      nulpos_q <= nulpos_d;
      tally_q  <= tally_d;
      err_q    <= err_d;
      code_q   <= code_d;
      eoff_q   <= eoff_d;
    end
  end

  // Track result buffer fill
  always_comb begin
    cnt_d = cnt_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Load head and tail words
  always_ff @(posedge clk_i) begin
    if (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)) begin
      if (push) begin
        head_q <= res;
      end
    end else if (cnt_q == 2'd1) begin
      if (push) begin
        tail_q <= res;
      end
    end else if (pop) begin
      head_q <= tail_q;
    end
  end

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = {{ipav_pkg::OutPadBits{1'b0}}, head_q};

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("result buffer overfilled");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (phase_q == ipav_pkg::PH_HEADER && bytes_q == 32'd0 && !err_q))
    else $error("state not cleared after final byte");

  a_err_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> (phase_q == ipav_pkg::PH_NAME_BODY || phase_q == ipav_pkg::PH_VER_BODY))
    else $error("error latched outside a field body");

  a_tally_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tally_q <= ipav_pkg::TALLY_MAX) else $error("package tally beyond saturation");

endmodule
